// ----- src/arst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range set table package
// Shared word types and operation and status codes.
// ----------------------------------------------------------------------------
package arst_pkg;

  typedef enum logic [1:0] {
    KIND_CHECK  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2,
    STATUS_RSVD = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] low_addr;
    logic [31:0] high_addr;
  } in_t;

  typedef struct packed {
    logic signed [9:0] result_value;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    logic [31:0] lower;
    logic [31:0] upper;
  } range_t;

endpackage

// ----- src/arst_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range memory
// One write port and one registered read port holding the range bounds.
// ----------------------------------------------------------------------------
module arst_mem #(
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output arst_pkg::range_t         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  arst_pkg::range_t         wdata_i
);

  arst_pkg::range_t mem_q [Depth];
  arst_pkg::range_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/address_range_set_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range set table
// Keeps disjoint inclusive address ranges; checks, adds and removes spans.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i and raise start while busy is low; the word is taken at
// that edge and busy rises unless the word is answered without a scan. One
// result word appears on result_o for exactly one cycle with result_valid_o
// high; the receiver cannot stall it. A rejected span or an unused kind answers
// in the cycle after the word is taken and leaves busy low. A check, and an add
// or a remove that is refused as full or a remove that meets no entry, reads
// every entry once through the memory read port and then answers.
// Any other add or remove scans the memory twice, once to count and once to
// drop entries and find free slots, then writes one entry in S_WRITE1 (none
// for a remove that swallows whole entries) and a second in S_WRITE2 when a
// remove leaves a piece on both sides; the result follows the last write.
// The memory's single read port serves both scans; one operation is in
// flight at a time.
// Reset empties the table at once: the valid flags and the entry count clear
// and busy drops; the range memory itself is not cleared.
// ----------------------------------------------------------------------------
module address_range_set_table_top #(
  parameter int unsigned MAX_RANGES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  arst_pkg::in_t    cmd_i,
  output logic             result_valid_o,
  output arst_pkg::out_t   result_o
);

  localparam int unsigned IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_RANGES - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_PURGE  = 5'b00100,
    S_WRITE1 = 5'b01000,
    S_WRITE2 = 5'b10000
  } state_e;

  state_e state_q, state_d;
  arst_pkg::in_t op_q, op_d;
  logic [IW-1:0] iss_q, iss_d, pidx_q, pidx_d, f1_q, f1_d, f2_q, f2_d;
  logic iss_on_q, iss_on_d, pvld_q, pvld_d, hf1_q, hf1_d, hf2_q, hf2_d;
  logic [CW-1:0] cnt_q, cnt_d, hits_q, hits_d;
  logic [MAX_RANGES-1:0] valid_q, valid_d;
  logic [31:0] acc_lo_q, acc_lo_d, acc_hi_q, acc_hi_d;
  logic [31:0] below_lo_q, below_lo_d, above_hi_q, above_hi_d;
  logic has_below_q, has_below_d, has_above_q, has_above_d;
  arst_pkg::out_t res_q, res_d;
  logic res_vld_q, res_vld_d;

  logic re, we;
  logic [IW-1:0] waddr;
  arst_pkg::range_t rdata, wdata;

  logic [31:0] cmp_lo, cmp_hi;
  logic ov, is_add;
  logic [CW:0] left_after;
  logic [1:0] pieces;

  arst_mem #(.Depth(MAX_RANGES)) u_mem (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (iss_q),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  assign is_add = (op_q.kind == arst_pkg::KIND_ADD);

  // An add also takes in neighbours that only touch the span; the widened
  // bounds saturate at the ends of the address space.
  always_comb begin
    cmp_lo = op_q.low_addr;
    cmp_hi = op_q.high_addr;
    if (is_add) begin
      if (op_q.low_addr != 32'd0) cmp_lo = op_q.low_addr - 32'd1;
      if (op_q.high_addr != 32'hFFFF_FFFF) cmp_hi = op_q.high_addr + 32'd1;
    end
  end

  assign ov = pvld_q && valid_q[pidx_q] && (rdata.lower <= cmp_hi) && (rdata.upper >= cmp_lo);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    iss_d       = iss_q;
    iss_on_d    = iss_on_q;
    pvld_d      = 1'b0;
    pidx_d      = iss_q;
    f1_d        = f1_q;
    f2_d        = f2_q;
    hf1_d       = hf1_q;
    hf2_d       = hf2_q;
    cnt_d       = cnt_q;
    hits_d      = hits_q;
    valid_d     = valid_q;
    acc_lo_d    = acc_lo_q;
    acc_hi_d    = acc_hi_q;
    below_lo_d  = below_lo_q;
    above_hi_d  = above_hi_q;
    has_below_d = has_below_q;
    has_above_d = has_above_q;
    res_d       = res_q;
    res_vld_d   = 1'b0;
    re          = 1'b0;
    we          = 1'b0;
    waddr       = f1_q;
    wdata       = '{lower: acc_lo_q, upper: acc_hi_q};
    pieces      = '0;
    left_after  = '0;

    if (state_q == S_SCAN || state_q == S_PURGE) begin
      if (iss_on_q) begin
        re       = 1'b1;
        pvld_d   = 1'b1;
        iss_d    = iss_q + IW'(1);
        if (iss_q == LastIdx) iss_on_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d        = cmd_i;
          hits_d      = '0;
          acc_lo_d    = cmd_i.low_addr;
          acc_hi_d    = cmd_i.high_addr;
          has_below_d = 1'b0;
          has_above_d = 1'b0;
          if (cmd_i.low_addr > cmd_i.high_addr) begin
            res_d     = '{result_value: '0, status: arst_pkg::STATUS_BAD};
            res_vld_d = 1'b1;
          end else if (cmd_i.kind == arst_pkg::KIND_NONE) begin
            res_d     = '{result_value: '0, status: arst_pkg::STATUS_DONE};
            res_vld_d = 1'b1;
          end else begin
            state_d  = S_SCAN;
            iss_d    = '0;
            iss_on_d = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (ov) begin
          hits_d = hits_q + CW'(1);
          if (rdata.lower < acc_lo_q) acc_lo_d = rdata.lower;
          if (rdata.upper > acc_hi_q) acc_hi_d = rdata.upper;
          if (rdata.lower < op_q.low_addr) begin
            has_below_d = 1'b1;
            below_lo_d  = rdata.lower;
          end
          if (rdata.upper > op_q.high_addr) begin
            has_above_d = 1'b1;
            above_hi_d  = rdata.upper;
          end
        end
        if (pvld_q && pidx_q == LastIdx) begin
          pieces     = 2'(has_below_d) + 2'(has_above_d);
          left_after = {1'b0, cnt_q} - {1'b0, hits_d} + (CW+1)'(pieces);
          priority if (op_q.kind == arst_pkg::KIND_CHECK) begin
            res_d     = '{result_value: 10'(hits_d), status: arst_pkg::STATUS_DONE};
            res_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else if ((is_add && hits_d == '0 && cnt_q >= CW'(MAX_RANGES)) ||
                       (!is_add && left_after > (CW+1)'(MAX_RANGES))) begin
            res_d     = '{result_value: '0, status: arst_pkg::STATUS_FULL};
            res_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else if (!is_add && hits_d == '0) begin
            res_d     = '{result_value: '0, status: arst_pkg::STATUS_DONE};
            res_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d  = S_PURGE;
            iss_d    = '0;
            iss_on_d = 1'b1;
            hf1_d    = 1'b0;
            hf2_d    = 1'b0;
          end
        end
      end
      S_PURGE: begin
        if (pvld_q) begin
          if (ov) begin
            valid_d[pidx_q] = 1'b0;
            cnt_d           = cnt_q - CW'(1);
          end
          // Slots freed by this pass count as free for the new entries.
          if (ov || !valid_q[pidx_q]) begin
            if (!hf1_q) begin
              hf1_d = 1'b1;
              f1_d  = pidx_q;
            end else if (!hf2_q) begin
              hf2_d = 1'b1;
              f2_d  = pidx_q;
            end
          end
          if (pidx_q == LastIdx) state_d = S_WRITE1;
        end
      end
      S_WRITE1: begin
        waddr = f1_q;
        if (!is_add) begin
          if (has_above_q) begin
            wdata = '{lower: op_q.high_addr + 32'd1, upper: above_hi_q};
          end else begin
            wdata = '{lower: below_lo_q, upper: op_q.low_addr - 32'd1};
          end
        end
        // A remove that swallows whole entries leaves nothing to write.
        if (is_add || has_above_q || has_below_q) begin
          we            = 1'b1;
          valid_d[f1_q] = 1'b1;
          cnt_d         = cnt_q + CW'(1);
        end
        if (!is_add && has_above_q && has_below_q) begin
          state_d = S_WRITE2;
        end else begin
          state_d   = S_IDLE;
          res_vld_d = 1'b1;
          res_d     = '{result_value: is_add ? (10'sd1 - 10'(hits_q)) : -10'(hits_q),
                        status: arst_pkg::STATUS_DONE};
        end
      end
      S_WRITE2: begin
        we            = 1'b1;
        waddr         = f2_q;
        wdata         = '{lower: below_lo_q, upper: op_q.low_addr - 32'd1};
        valid_d[f2_q] = 1'b1;
        cnt_d         = cnt_q + CW'(1);
        state_d       = S_IDLE;
        res_vld_d     = 1'b1;
        res_d         = '{result_value: -10'(hits_q), status: arst_pkg::STATUS_DONE};
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_on_q  <= 1'b0;
      pvld_q    <= 1'b0;
      cnt_q     <= '0;
      valid_q   <= '0;
      res_vld_q <= 1'b0;
      hf1_q     <= 1'b0;
      hf2_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_on_q  <= iss_on_d;
      pvld_q    <= pvld_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      res_vld_q <= res_vld_d;
      hf1_q     <= hf1_d;
      hf2_q     <= hf2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    iss_q       <= iss_d;
    pidx_q      <= pidx_d;
    f1_q        <= f1_d;
    f2_q        <= f2_d;
    hits_q      <= hits_d;
    acc_lo_q    <= acc_lo_d;
    acc_hi_q    <= acc_hi_d;
    below_lo_q  <= below_lo_d;
    above_hi_q  <= above_hi_d;
    has_below_q <= has_below_d;
    has_above_q <= has_above_d;
    res_q       <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule
